/* design/crc_framed_serial_transmitter_assert.svh */
// Assertion macros used by the checker file of the CRC framed transmitter.
// Needs nothing else; every macro expands to one labeled concurrent assertion.
`ifndef CRC_FRAMED_SERIAL_TRANSMITTER_ASSERT_SVH
`define CRC_FRAMED_SERIAL_TRANSMITTER_ASSERT_SVH

// Property holds at every edge outside reset.
`define CRCFST_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in this cycle implies a condition in the next cycle.
`define CRCFST_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
		else $error(msg);

`endif

/* design/crcfst_pkg.sv */
// Package of the CRC framed serial transmitter: word types, frame constants
// and the CRC helper functions. Depends on nothing.
`default_nettype none

package crcfst_pkg;

	// Fixed frame layout
	localparam int ADDR_BITS  = 8;
	localparam int BYTE_BITS  = 8;
	localparam int CHECK_BITS = 6;
	localparam int REM_BITS   = 5;

	// Generator x^5 + x^3 + x^2 + 1, leading term dropped
	localparam logic [REM_BITS-1:0] POLY_LOW = 5'h0D;

	// Defaults for the top level parameters
	localparam int DEF_DATA_BYTES  = 4;
	localparam int DEF_START_TICKS = 10;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
	} in_word_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic frame_done;
		logic byte_dropped;
	} out_word_t;

	// One long-division step: shift in one message bit
	function automatic logic [REM_BITS-1:0] div_step(input logic [REM_BITS-1:0] rem,
		input logic bit_in);
		logic [REM_BITS-1:0] r;
		r = {rem[REM_BITS-2:0], bit_in};
		if (rem[REM_BITS-1])
			r = r ^ POLY_LOW;
		return r;
	endfunction

	// x^n mod G; called with constant arguments only, folds at elaboration
	function automatic logic [REM_BITS-1:0] pow_rem(input int n);
		logic [REM_BITS-1:0] r;
		r = REM_BITS'(1);
		for (int k = 0; k < n; k++)
			r = div_step(r, 1'b0);
		return r;
	endfunction

endpackage

`default_nettype wire

/* design/crc_framed_serial_transmitter.sv */
// CRC framed serial transmitter: top level, byte collection, CRC and bit timing.
// Depends on crcfst_pkg.
`default_nettype none

// One input word is taken per clock when in_stall is low; each word yields
// exactly one result word, which is registered. A single
// skid entry behind the result register keeps the input open while a result
// waits; in_stall rises only when that entry is also occupied. A data word
// (cmd 0) is shifted into the collection register and folds its byte into a
// running CRC remainder (eight division steps); the byte that completes a set
// of DATA_BYTES adds the station address and the six appended zeros through
// constant XOR columns and loads the frame shift register in the same cycle,
// so the line goes high with that result. Tick words (cmd 1) in a frame
// advance the tick counter; every second tick from START_TICKS on shifts
// the next frame bit onto the line, and tick START_TICKS + 2 * frame length
// ends the frame. Data words that arrive during a frame are dropped and
// flagged. The address register is written through cfg_wr_en / cfg_wr_data
// and should only be changed between frames.
module crc_framed_serial_transmitter #(
	parameter int DATA_BYTES  = crcfst_pkg::DEF_DATA_BYTES,
	parameter int START_TICKS = crcfst_pkg::DEF_START_TICKS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [7:0]            cfg_wr_data,
	input  wire logic                  in_valid,
	output      logic                  in_stall,
	input  wire crcfst_pkg::in_word_t  in_word,
	output      logic                  out_valid,
	input  wire logic                  out_stall,
	output      crcfst_pkg::out_word_t out_word
);
	import crcfst_pkg::*;

	localparam int DATA_W    = BYTE_BITS * DATA_BYTES;
	localparam int MSG_BITS  = ADDR_BITS + DATA_W;
	localparam int FRAME_LEN = MSG_BITS + CHECK_BITS;
	localparam int END_TICK  = START_TICKS + 2 * FRAME_LEN;
	localparam int TICK_W    = $clog2(END_TICK + 1);
	localparam int CNT_W     = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
	localparam logic START_ODD = 1'((START_TICKS % 2) != 0);

	// Block state
	logic [7:0]           addr_q;
	logic [DATA_W-1:0]    data_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [REM_BITS-1:0]  crc_q;
	logic [FRAME_LEN-1:0] frame_q;
	logic [TICK_W-1:0]    tick_q;
	logic                 sending_q;
	logic                 line_q;

	// Output register and skid entry
	out_word_t out_q, skid_q;
	logic      out_v_q, skid_v_q;

	logic accept;
	assign in_stall = skid_v_q;
	assign accept   = in_valid && !in_stall;

	// Next-state values
	logic [DATA_W-1:0]    data_n;
	logic [CNT_W-1:0]     cnt_n;
	logic [REM_BITS-1:0]  crc_n;
	logic [FRAME_LEN-1:0] frame_n;
	logic [TICK_W-1:0]    tick_n;
	logic                 sending_n;
	logic                 line_n;
	out_word_t            res;

	// CRC and frame assembly
	logic [REM_BITS-1:0]  crc_byte;
	logic [REM_BITS-1:0]  crc_full;
	logic [DATA_W-1:0]    data_shift;
	logic [FRAME_LEN-1:0] frame_load;
	logic [TICK_W-1:0]    tick_inc;
	logic                 last_byte;

	// Fold the incoming byte into the running remainder, MSB first
	always_comb begin
		crc_byte = crc_q;
		for (int b = BYTE_BITS - 1; b >= 0; b--)
			crc_byte = div_step(crc_byte, in_word.data_byte[b]);
	end

	// Complete remainder: address at its degree plus data times x^6
	always_comb begin
		crc_full = '0;
		for (int i = 0; i < ADDR_BITS; i++)
			if (addr_q[i])
				crc_full = crc_full ^ pow_rem(MSG_BITS - 1 - i + CHECK_BITS);
		for (int j = 0; j < REM_BITS; j++)
			if (crc_byte[j])
				crc_full = crc_full ^ pow_rem(j + CHECK_BITS);
	end

	assign data_shift = DATA_W'({data_q, in_word.data_byte});
	assign last_byte  = (cnt_q == CNT_W'(DATA_BYTES - 1));
	assign tick_inc   = tick_q + TICK_W'(1);

	// Frame vector, bit 0 goes out first
	always_comb begin
		frame_load = '0;
		for (int i = 0; i < ADDR_BITS; i++)
			frame_load[i] = addr_q[i];
		for (int m = 0; m < DATA_W; m++)
			frame_load[ADDR_BITS + m] = data_shift[DATA_W - 1 - m];
		frame_load[MSG_BITS] = 1'b0;
		for (int i = 0; i < REM_BITS; i++)
			frame_load[FRAME_LEN - REM_BITS + i] = crc_full[REM_BITS - 1 - i];
	end

	// Per-word state update and result
	always_comb begin
		data_n    = data_q;
		cnt_n     = cnt_q;
		crc_n     = crc_q;
		frame_n   = frame_q;
		tick_n    = tick_q;
		sending_n = sending_q;
		line_n    = line_q;
		res       = '0;
		if (!in_word.cmd) begin
			if (sending_q) begin
				res.byte_dropped = 1'b1;
			end else begin
				data_n = data_shift;
				if (last_byte) begin
					cnt_n     = '0;
					crc_n     = '0;
					frame_n   = frame_load;
					sending_n = 1'b1;
					line_n    = 1'b1;
					tick_n    = '0;
				end else begin
					cnt_n = cnt_q + CNT_W'(1);
					crc_n = crc_byte;
				end
			end
		end else if (sending_q) begin
			tick_n = tick_inc;
			if (tick_inc == TICK_W'(END_TICK)) begin
				line_n         = 1'b0;
				sending_n      = 1'b0;
				tick_n         = '0;
				res.frame_done = 1'b1;
			end else if (tick_inc >= TICK_W'(START_TICKS) &&
				(tick_inc[0] == START_ODD)) begin
				line_n  = frame_q[0];
				frame_n = frame_q >> 1;
			end
		end
		res.line_level = line_n;
		res.busy_res   = sending_n;
	end

	// Station address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			addr_q <= '0;
		else if (cfg_wr_en)
			addr_q <= cfg_wr_data;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			crc_q     <= '0;
			tick_q    <= '0;
			sending_q <= 1'b0;
			line_q    <= 1'b0;
		end else if (accept) begin
			cnt_q     <= cnt_n;
			crc_q     <= crc_n;
			tick_q    <= tick_n;
			sending_q <= sending_n;
			line_q    <= line_n;
		end
	end

	// Data and frame payload
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q  <= data_n;
			frame_q <= frame_n;
		end
	end

	// Result register with one skid entry
	logic out_free;
	assign out_free = !out_v_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q  <= skid_v_q || accept;
			skid_v_q <= 1'b0;
		end else if (accept) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_v_q)
				out_q <= skid_q;
			else if (accept)
				out_q <= res;
		end else if (accept) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_v_q;
	assign out_word  = out_q;

endmodule

`default_nettype wire

/* design/crcfst_checker.sv */
// Port-level checker for the CRC framed serial transmitter, bound to the top.
// Depends on crcfst_pkg and crc_framed_serial_transmitter_assert.svh.
`default_nettype none

`include "crc_framed_serial_transmitter_assert.svh"

module crcfst_checker (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  out_valid,
	input wire logic                  out_stall,
	input wire crcfst_pkg::out_word_t out_word
);
	import crcfst_pkg::*;

	// Shorthands for what the result port shows
	logic out_held, line_bad, drop_bad, done_bad;
	assign out_held = out_valid && out_stall;
	assign line_bad = out_valid && !out_word.busy_res && out_word.line_level;
	assign drop_bad = out_valid && out_word.byte_dropped && !out_word.busy_res;
	assign done_bad = out_valid && out_word.frame_done &&
		(out_word.byte_dropped || out_word.busy_res);

	// A stalled result word stays put
	`CRCFST_ASSERT_NEXT(a_out_hold, clk, arst_n, out_held, $stable(out_word), "held word moved")
	`CRCFST_ASSERT_NEXT(a_valid_hold, clk, arst_n, out_held, out_valid, "valid dropped on stall")

	// The line idles low outside a frame
	`CRCFST_ASSERT(a_idle_low, clk, arst_n, !line_bad, "line high while not busy")

	// A dropped byte means a frame is still in flight
	`CRCFST_ASSERT(a_drop_busy, clk, arst_n, !drop_bad, "byte dropped while idle")

	// Frame end comes from a tick, and leaves the block idle
	`CRCFST_ASSERT(a_done_clean, clk, arst_n, !done_bad, "frame end flagged with busy or drop")

endmodule

bind crc_framed_serial_transmitter crcfst_checker u_crcfst_checker (.*);

`default_nettype wire
